[rtl/iols_pkg.sv]
`default_nettype none

package iols_pkg;

	localparam int unsigned CAPACITY_DEF = 256;

	typedef enum logic [1:0] {
		FN_INSERT = 2'd0,
		FN_REMOVE = 2'd1,
		FN_READ   = 2'd2,
		FN_CLEAR  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		func_t              func;
		logic [7:0]         position;
		logic signed [31:0] value_in;
	} req_t;

	typedef struct packed {
		logic signed [31:0] value_out;
		status_t            status;
		logic [8:0]         count;
	} rsp_t;

	// what a memory read does in the following cycle
	typedef enum logic [1:0] {
		RD_CAP = 2'd0,  // capture as result value
		RD_UP  = 2'd1,  // write one slot higher
		RD_DN  = 2'd2   // write one slot lower
	} rd_mode_t;

	typedef enum logic [1:0] {
		IDX_NM1  = 2'd0,  // last entry
		IDX_PREM = 2'd1,  // clamped remove position
		IDX_POS  = 2'd2   // raw request position
	} idx_src_t;

	typedef struct packed {
		logic     cap_req;
		logic     set_st;
		status_t  st;
		logic     clr_fill;
		logic     inc_fill;
		logic     dec_fill;
		logic     idx_ld;
		idx_src_t idx_src;
		logic     idx_inc;
		logic     idx_dec;
		logic     rd_en;
		rd_mode_t rd_mode;
		logic     put;
		logic     load_out;
	} cmd_t;

	typedef struct packed {
		func_t func;
		logic  full;
		logic  empty;
		logic  rd_oob;
		logic  ins_at_end;
		logic  idx_at_p;
		logic  idx_last;
		logic  out_busy;
	} sts_t;

endpackage

`default_nettype wire

[rtl/iols_dp.sv]
`default_nettype none

module iols_dp #(
	parameter int unsigned CAPACITY = iols_pkg::CAPACITY_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire iols_pkg::req_t req,
	input  wire iols_pkg::cmd_t cmd,
	output iols_pkg::sts_t      sts,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output iols_pkg::rsp_t      rsp
);

	localparam int unsigned AW   = $clog2(CAPACITY);
	localparam int unsigned CW   = $clog2(CAPACITY + 1);
	localparam int unsigned CMPW = (CW > 8) ? CW : 8;

	logic signed [31:0] mem [CAPACITY];

	iols_pkg::func_t    func_q;
	logic [7:0]         pos_q;
	logic signed [31:0] val_q;
	logic [CW-1:0]      fill_q;
	logic [CW-1:0]      idx_q;
	logic signed [31:0] res_q;
	iols_pkg::status_t  status_q;

	logic                 pend_s1;
	iols_pkg::rd_mode_t   mode_s1;
	logic [AW-1:0]        addr_s1;
	logic signed [31:0]   rdata_s1;

	logic                 rsp_valid_q;
	iols_pkg::rsp_t       rsp_q;

	logic [CMPW-1:0]      pos_ext;
	logic [CMPW-1:0]      fill_ext;
	logic [CW-1:0]        fill_m1;
	logic [CW-1:0]        p_ins;
	logic [CW-1:0]        p_rem;
	logic                 we;
	logic [AW-1:0]        waddr;
	logic signed [31:0]   wdata;
	logic [CW-1:0]        idx_src_val;

	assign pos_ext  = CMPW'(pos_q);
	assign fill_ext = CMPW'(fill_q);
	assign fill_m1  = fill_q - CW'(1);
	assign p_ins    = (pos_ext >= fill_ext) ? fill_q : CW'(pos_q);
	assign p_rem    = (pos_ext >= CMPW'(fill_m1)) ? fill_m1 : CW'(pos_q);

	always_comb begin
		sts.func       = func_q;
		sts.full       = (fill_q == CW'(CAPACITY));
		sts.empty      = (fill_q == '0);
		sts.rd_oob     = (pos_ext >= fill_ext);
		sts.ins_at_end = (p_ins == fill_q);
		sts.idx_at_p   = (idx_q == p_ins);
		sts.idx_last   = (idx_q == fill_m1);
		sts.out_busy   = rsp_valid_q && rsp_stall;
	end

	always_comb begin
		unique case (cmd.idx_src)
			iols_pkg::IDX_NM1:  idx_src_val = fill_m1;
			iols_pkg::IDX_PREM: idx_src_val = p_rem;
			iols_pkg::IDX_POS:  idx_src_val = CW'(pos_q);
			default:            idx_src_val = CW'(pos_q);
		endcase
	end

	// single write port: the value store and the shift write never coincide
	always_comb begin
		we    = 1'b0;
		waddr = p_ins[AW-1:0];
		wdata = val_q;
		if (cmd.put) begin
			we = 1'b1;
		end else if (pend_s1 && mode_s1 != iols_pkg::RD_CAP) begin
			we    = 1'b1;
			wdata = rdata_s1;
			waddr = (mode_s1 == iols_pkg::RD_UP) ? addr_s1 + AW'(1) : addr_s1 - AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (cmd.rd_en) begin
			rdata_s1 <= mem[idx_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			pend_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			pend_s1 <= cmd.rd_en;
			if (cmd.clr_fill) begin
				fill_q <= '0;
			end else if (cmd.inc_fill) begin
				fill_q <= fill_q + CW'(1);
			end else if (cmd.dec_fill) begin
				fill_q <= fill_m1;
			end
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_req) begin
			func_q   <= req.func;
			pos_q    <= req.position;
			val_q    <= req.value_in;
			res_q    <= '0;
			status_q <= iols_pkg::ST_OK;
		end else begin
			if (cmd.set_st) begin
				status_q <= cmd.st;
			end
			if (pend_s1 && mode_s1 == iols_pkg::RD_CAP) begin
				res_q <= rdata_s1;
			end
		end
		if (cmd.rd_en) begin
			mode_s1 <= cmd.rd_mode;
			addr_s1 <= idx_q[AW-1:0];
		end
		if (cmd.idx_ld) begin
			idx_q <= idx_src_val;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + CW'(1);
		end else if (cmd.idx_dec) begin
			idx_q <= idx_q - CW'(1);
		end
		if (cmd.load_out) begin
			rsp_q.value_out <= res_q;
			rsp_q.status    <= status_q;
			rsp_q.count     <= 9'(fill_q);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

[rtl/iols_ctrl.sv]
`default_nettype none

module iols_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire iols_pkg::sts_t sts,
	output iols_pkg::cmd_t      cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_EXEC,
		S_CAPT,
		S_DN,
		S_UP,
		S_FLUSH,
		S_PUT,
		S_DRAIN,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.cap_req = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				unique case (sts.func)
					iols_pkg::FN_INSERT: begin
						if (sts.full) begin
							cmd.set_st = 1'b1;
							cmd.st     = iols_pkg::ST_FULL;
							state_d    = S_DONE;
						end else if (sts.ins_at_end) begin
							state_d = S_PUT;
						end else begin
							cmd.idx_ld  = 1'b1;
							cmd.idx_src = iols_pkg::IDX_NM1;
							state_d     = S_UP;
						end
					end
					iols_pkg::FN_REMOVE: begin
						if (sts.empty) begin
							cmd.set_st = 1'b1;
							cmd.st     = iols_pkg::ST_EMPTY;
							state_d    = S_DONE;
						end else begin
							cmd.idx_ld  = 1'b1;
							cmd.idx_src = iols_pkg::IDX_PREM;
							state_d     = S_CAPT;
						end
					end
					iols_pkg::FN_READ: begin
						if (sts.rd_oob) begin
							cmd.set_st = 1'b1;
							cmd.st     = iols_pkg::ST_EMPTY;
							state_d    = S_DONE;
						end else begin
							cmd.idx_ld  = 1'b1;
							cmd.idx_src = iols_pkg::IDX_POS;
							state_d     = S_CAPT;
						end
					end
					iols_pkg::FN_CLEAR: begin
						cmd.clr_fill = 1'b1;
						state_d      = S_DONE;
					end
					default: state_d = S_DONE;
				endcase
			end
			S_CAPT: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_mode = iols_pkg::RD_CAP;
				if (sts.func == iols_pkg::FN_REMOVE && !sts.idx_last) begin
					cmd.idx_inc = 1'b1;
					state_d     = S_DN;
				end else begin
					state_d = S_DRAIN;
				end
			end
			S_DN: begin
				// entry idx moves down to idx-1 next cycle
				cmd.rd_en   = 1'b1;
				cmd.rd_mode = iols_pkg::RD_DN;
				if (sts.idx_last) begin
					state_d = S_DRAIN;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			S_UP: begin
				// entry idx moves up to idx+1 next cycle
				cmd.rd_en   = 1'b1;
				cmd.rd_mode = iols_pkg::RD_UP;
				if (sts.idx_at_p) begin
					state_d = S_FLUSH;
				end else begin
					cmd.idx_dec = 1'b1;
				end
			end
			S_FLUSH: begin
				state_d = S_PUT;
			end
			S_PUT: begin
				cmd.put      = 1'b1;
				cmd.inc_fill = 1'b1;
				state_d      = S_DONE;
			end
			S_DRAIN: begin
				cmd.dec_fill = (sts.func == iols_pkg::FN_REMOVE);
				state_d      = S_DONE;
			end
			S_DONE: begin
				if (!sts.out_busy) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_stall = (state_q != S_IDLE);

endmodule

`default_nettype wire

[rtl/indexed_ordered_list_store.sv]
// channel | dir | handshake              | payload
// req     | in  | req_valid / req_stall  | iols_pkg::req_t (func, position, value_in)
// rsp     | out | rsp_valid / rsp_stall  | iols_pkg::rsp_t (value_out, status, count)
//
// Insert shifts entries from position up one slot, then writes; append just writes.
// Remove reads, then shifts the entries above down a slot; read only reads the entry.
// The shift walks the entry memory through its single read and single write port.
// arst_n clears the length and control; entry contents are not cleared.
// A response waiting under rsp_stall does not block the next request from
// being taken; a finished result waits in its final state until the output is free.
`default_nettype none

module indexed_ordered_list_store #(
	parameter int unsigned CAPACITY = iols_pkg::CAPACITY_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire iols_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output iols_pkg::rsp_t      rsp
);

	iols_pkg::cmd_t cmd;
	iols_pkg::sts_t sts;

	iols_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	iols_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

[rtl/iols_checker.sv]
`default_nettype none

module iols_checker #(
	parameter int unsigned CAPACITY = iols_pkg::CAPACITY_DEF
) (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           req_valid,
	input wire logic           req_stall,
	input wire logic           rsp_valid,
	input wire logic           rsp_stall,
	input wire iols_pkg::rsp_t rsp
);

	localparam logic [8:0] CAP9 = 9'(CAPACITY);

	// a stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response changed under stall");

	// a taken request makes the block busy in the following cycle
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request not followed by busy");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != iols_pkg::ST_OK |-> rsp.value_out == '0)
		else $error("value_out not zero on error status");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == iols_pkg::ST_FULL |-> rsp.count == CAP9)
		else $error("full status with count below capacity");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (CAPACITY > 511) || (rsp.count <= CAP9))
		else $error("count above capacity");

endmodule

bind indexed_ordered_list_store iols_checker #(
	.CAPACITY (CAPACITY)
) u_iols_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

`default_nettype wire
